/* sv/scft_pkg.sv */
package scft_pkg;

	// Field and port widths
	localparam int DataW    = 8;
	localparam int LenW     = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int CrcW     = 32;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MAGIC       = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_VERSION     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FRAME_TYPE  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_END_CODE    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ESC_CODE    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ESC_END     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ESC_ESC     = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD = 3'd7;

	// Register reset values
	localparam logic [DataW-1:0] RST_MAGIC       = 8'd165;
	localparam logic [DataW-1:0] RST_VERSION     = 8'd1;
	localparam logic [DataW-1:0] RST_FRAME_TYPE  = 8'd1;
	localparam logic [DataW-1:0] RST_END_CODE    = 8'd192;
	localparam logic [DataW-1:0] RST_ESC_CODE    = 8'd219;
	localparam logic [DataW-1:0] RST_ESC_END     = 8'd220;
	localparam logic [DataW-1:0] RST_ESC_ESC     = 8'd221;
	localparam logic [LenW-1:0]  RST_MAX_PAYLOAD = 16'd512;

	// Header flag bit positions
	localparam int FLAG_CHUNKED = 0;
	localparam int FLAG_START   = 1;
	localparam int FLAG_END     = 2;

	// Reflected CRC-32
	localparam logic [CrcW-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CRC_INIT = 32'hFFFF_FFFF;

	// SLIP codes and fixed header bytes
	typedef struct packed {
		logic [DataW-1:0] magic;
		logic [DataW-1:0] version;
		logic [DataW-1:0] ftype;
		logic [DataW-1:0] end_code;
		logic [DataW-1:0] esc_code;
		logic [DataW-1:0] esc_end;
		logic [DataW-1:0] esc_esc;
	} slip_cfg_t;

	// Work for one input item: optional frame opening, data byte, optional closing
	typedef struct packed {
		logic             start;
		logic             close;
		logic [DataW-1:0] flags;
		logic [LenW-1:0]  seq;
		logic [LenW-1:0]  msg_id;
		logic [LenW-1:0]  chunk_len;
		logic [DataW-1:0] data;
	} frame_desc_t;

	// Raw byte position within a frame
	typedef enum logic [16:0] {
		P_OPEN   = 17'b0_0000_0000_0000_0001,
		P_MAGIC  = 17'b0_0000_0000_0000_0010,
		P_VER    = 17'b0_0000_0000_0000_0100,
		P_TYPE   = 17'b0_0000_0000_0000_1000,
		P_FLAGS  = 17'b0_0000_0000_0001_0000,
		P_SEQ_L  = 17'b0_0000_0000_0010_0000,
		P_SEQ_H  = 17'b0_0000_0000_0100_0000,
		P_ID_L   = 17'b0_0000_0000_1000_0000,
		P_ID_H   = 17'b0_0000_0001_0000_0000,
		P_LEN_L  = 17'b0_0000_0010_0000_0000,
		P_LEN_H  = 17'b0_0000_0100_0000_0000,
		P_DATA   = 17'b0_0000_1000_0000_0000,
		P_CRC0   = 17'b0_0001_0000_0000_0000,
		P_CRC1   = 17'b0_0010_0000_0000_0000,
		P_CRC2   = 17'b0_0100_0000_0000_0000,
		P_CRC3   = 17'b0_1000_0000_0000_0000,
		P_CLOSE  = 17'b1_0000_0000_0000_0000
	} pos_t;

	// One byte through the reflected CRC, bit at a time
	function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
		input logic [DataW-1:0] b);
		logic [CrcW-1:0] c;
		int              i;
		c = crc ^ {{(CrcW-DataW){1'b0}}, b};
		for (i = 0; i < DataW; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* sv/slip_crc_frame_transmitter.sv */
// An item's first encoded byte passes the input, descriptor and output registers.
// Throughput: one encoded byte per cycle while m_tready is high; an item gives 1 to 32
// bytes (header, SLIP escapes, CRC and delimiters); the output stream sets the item rate.
// The next item is taken as soon as the previous one has entered the serializer.
// Reset: counters cleared, CRC to all ones, configuration registers to defaults.
module slip_crc_frame_transmitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // data_byte [7:0], message_length [23:8]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [scft_pkg::DataW-1:0]    m_tdata,   // tx_byte [7:0]
	output logic                          m_tlast,   // last_of_run
	output logic                          m_tuser,   // frame_done
	input  logic                          cfg_we,
	input  logic [scft_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scft_pkg::CfgDataW-1:0] cfg_data
);

	localparam int LW = scft_pkg::LenW;

	// Configuration registers
	scft_pkg::slip_cfg_t cfg_q;
	logic [LW-1:0]       max_pl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic    <= scft_pkg::RST_MAGIC;
			cfg_q.version  <= scft_pkg::RST_VERSION;
			cfg_q.ftype    <= scft_pkg::RST_FRAME_TYPE;
			cfg_q.end_code <= scft_pkg::RST_END_CODE;
			cfg_q.esc_code <= scft_pkg::RST_ESC_CODE;
			cfg_q.esc_end  <= scft_pkg::RST_ESC_END;
			cfg_q.esc_esc  <= scft_pkg::RST_ESC_ESC;
			max_pl_q       <= scft_pkg::RST_MAX_PAYLOAD;
		end else if (cfg_we) begin
			case (cfg_index)
				scft_pkg::REG_MAGIC:       cfg_q.magic    <= cfg_data[7:0];
				scft_pkg::REG_VERSION:     cfg_q.version  <= cfg_data[7:0];
				scft_pkg::REG_FRAME_TYPE:  cfg_q.ftype    <= cfg_data[7:0];
				scft_pkg::REG_END_CODE:    cfg_q.end_code <= cfg_data[7:0];
				scft_pkg::REG_ESC_CODE:    cfg_q.esc_code <= cfg_data[7:0];
				scft_pkg::REG_ESC_END:     cfg_q.esc_end  <= cfg_data[7:0];
				scft_pkg::REG_ESC_ESC:     cfg_q.esc_esc  <= cfg_data[7:0];
				scft_pkg::REG_MAX_PAYLOAD: max_pl_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Message and chunk state
	logic [LW-1:0] seq_q, id_ctr_q, off_q, crem_q, cur_id_q, total_q;
	logic          chunked_q;

	logic [scft_pkg::DataW-1:0] in_byte;
	logic [LW-1:0]              in_len;
	logic                       accept;
	logic                       start_msg;
	logic                       ignore;
	logic [LW-1:0]              eff_max;
	logic [LW-1:0]              tot_e;
	logic                       chk_e;
	logic [LW-1:0]              id_inc;
	logic [LW-1:0]              id_e;
	logic                       new_chunk;
	logic [LW-1:0]              rest;
	logic [LW-1:0]              chunk;
	logic                       last_chunk;
	logic [LW-1:0]              crem_e;
	logic [LW-1:0]              crem_n;
	logic [LW-1:0]              off_n;
	logic                       close;
	logic [scft_pkg::DataW-1:0] flags;
	logic [LW:0]                inv_sum;

	assign in_byte   = s_tdata[7:0];
	assign in_len    = s_tdata[23:8];
	assign accept    = s_tvalid && s_tready;
	assign start_msg = (off_q == '0) && (crem_q == '0);
	assign ignore    = start_msg && (in_len == '0);
	assign eff_max   = (max_pl_q == '0) ? LW'(1) : max_pl_q;
	assign tot_e     = start_msg ? in_len : total_q;
	assign chk_e     = start_msg ? (in_len > eff_max) : chunked_q;
	assign id_inc    = id_ctr_q + LW'(1);
	assign id_e      = start_msg ? (chk_e ? id_inc : '0) : cur_id_q;
	assign new_chunk = crem_q == '0;
	assign rest      = tot_e - off_q;
	assign chunk     = (rest > eff_max) ? eff_max : rest;
	assign last_chunk = ({1'b0, off_q} + {1'b0, chunk}) >= {1'b0, tot_e};
	assign crem_e    = new_chunk ? chunk : crem_q;
	assign crem_n    = crem_e - LW'(1);
	assign off_n     = off_q + LW'(1);
	assign close     = crem_n == '0;
	assign inv_sum   = {1'b0, off_q} + {1'b0, crem_q};

	// Header flags for a new chunk
	always_comb begin
		flags = '0;
		if (chk_e) begin
			flags[scft_pkg::FLAG_CHUNKED] = 1'b1;
			flags[scft_pkg::FLAG_START]   = off_q == '0;
			flags[scft_pkg::FLAG_END]     = last_chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= '0;
			id_ctr_q  <= '0;
			off_q     <= '0;
			crem_q    <= '0;
			cur_id_q  <= '0;
			total_q   <= '0;
			chunked_q <= 1'b0;
		end else if (accept && !ignore) begin
			if (start_msg) begin
				total_q   <= in_len;
				chunked_q <= chk_e;
				cur_id_q  <= id_e;
				if (chk_e) begin
					id_ctr_q <= id_inc;
				end
			end
			crem_q <= crem_n;
			if (close) begin
				seq_q <= seq_q + LW'(1);
				off_q <= (off_n >= tot_e) ? '0 : off_n;
			end else begin
				off_q <= off_n;
			end
		end
	end

	// Input register holding the work for one item
	scft_pkg::frame_desc_t desc_s1;
	logic                  desc_v_s1;
	logic                  ser_ready;

	assign s_tready = !desc_v_s1 || ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_v_s1 <= 1'b0;
		end else if (accept && !ignore) begin
			desc_v_s1 <= 1'b1;
		end else if (ser_ready) begin
			desc_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !ignore) begin
			desc_s1.start     <= new_chunk;
			desc_s1.close     <= close;
			desc_s1.flags     <= flags;
			desc_s1.seq       <= seq_q;
			desc_s1.msg_id    <= id_e;
			desc_s1.chunk_len <= chunk;
			desc_s1.data      <= in_byte;
		end
	end

	scft_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.desc_valid (desc_v_s1),
		.desc_ready (ser_ready),
		.desc       (desc_s1),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// The closing end code is always the last byte of its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame_done without last_of_run");

	// An open chunk never runs past the message end
	a_chunk_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		inv_sum <= {1'b0, total_q})
		else $error("chunk extends beyond message");

	// With the input register empty a transaction is always taken
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!desc_v_s1 |-> s_tready)
		else $error("input stalled while empty");

	// An ignored item leaves the chunk state unchanged
	a_ignore_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ignore |=> (crem_q == $past(crem_q)) && (off_q == $past(off_q)))
		else $error("empty message changed state");

endmodule

/* sv/scft_serializer.sv */
module scft_serializer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  scft_pkg::slip_cfg_t      cfg,
	input  logic                     desc_valid,
	output logic                     desc_ready,
	input  scft_pkg::frame_desc_t    desc,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [scft_pkg::DataW-1:0] m_tdata,  // tx_byte [7:0]
	output logic                     m_tlast,
	output logic                     m_tuser    // frame_done
);

	logic                           cur_v_q;
	scft_pkg::frame_desc_t          desc_q;
	scft_pkg::pos_t                 pos_q;
	scft_pkg::pos_t                 pos_nxt;
	logic                           esc2_q;
	logic [scft_pkg::CrcW-1:0]      crc_q;
	logic [scft_pkg::CrcW-1:0]      crc_inv;
	logic                           m_tvalid_q;
	logic [scft_pkg::DataW-1:0]     m_tdata_q;
	logic                           m_tlast_q;
	logic                           m_tuser_q;

	logic                           out_free;
	logic                           step;
	logic [scft_pkg::DataW-1:0]     raw;
	logic                           escapable;
	logic                           feed_en;
	logic                           finish;
	logic                           is_end;
	logic                           is_esc;
	logic                           first_half;
	logic                           advance;
	logic                           done;
	logic [scft_pkg::DataW-1:0]     out_byte;

	assign crc_inv  = ~crc_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign step     = cur_v_q && out_free;

	// Raw byte at the current position and where to go next
	always_comb begin
		raw       = desc_q.data;
		escapable = 1'b1;
		feed_en   = 1'b1;
		finish    = 1'b0;
		pos_nxt   = scft_pkg::P_CLOSE;
		case (pos_q)
			scft_pkg::P_OPEN: begin
				raw = cfg.end_code; escapable = 1'b0; feed_en = 1'b0;
				pos_nxt = scft_pkg::P_MAGIC;
			end
			scft_pkg::P_MAGIC: begin
				raw = cfg.magic; feed_en = 1'b0; pos_nxt = scft_pkg::P_VER;
			end
			scft_pkg::P_VER: begin
				raw = cfg.version; pos_nxt = scft_pkg::P_TYPE;
			end
			scft_pkg::P_TYPE: begin
				raw = cfg.ftype; pos_nxt = scft_pkg::P_FLAGS;
			end
			scft_pkg::P_FLAGS: begin
				raw = desc_q.flags; pos_nxt = scft_pkg::P_SEQ_L;
			end
			scft_pkg::P_SEQ_L: begin
				raw = desc_q.seq[7:0]; pos_nxt = scft_pkg::P_SEQ_H;
			end
			scft_pkg::P_SEQ_H: begin
				raw = desc_q.seq[15:8]; pos_nxt = scft_pkg::P_ID_L;
			end
			scft_pkg::P_ID_L: begin
				raw = desc_q.msg_id[7:0]; pos_nxt = scft_pkg::P_ID_H;
			end
			scft_pkg::P_ID_H: begin
				raw = desc_q.msg_id[15:8]; pos_nxt = scft_pkg::P_LEN_L;
			end
			scft_pkg::P_LEN_L: begin
				raw = desc_q.chunk_len[7:0]; pos_nxt = scft_pkg::P_LEN_H;
			end
			scft_pkg::P_LEN_H: begin
				raw = desc_q.chunk_len[15:8]; pos_nxt = scft_pkg::P_DATA;
			end
			scft_pkg::P_DATA: begin
				raw = desc_q.data; finish = !desc_q.close; pos_nxt = scft_pkg::P_CRC0;
			end
			scft_pkg::P_CRC0: begin
				raw = crc_inv[7:0]; feed_en = 1'b0; pos_nxt = scft_pkg::P_CRC1;
			end
			scft_pkg::P_CRC1: begin
				raw = crc_inv[15:8]; feed_en = 1'b0; pos_nxt = scft_pkg::P_CRC2;
			end
			scft_pkg::P_CRC2: begin
				raw = crc_inv[23:16]; feed_en = 1'b0; pos_nxt = scft_pkg::P_CRC3;
			end
			scft_pkg::P_CRC3: begin
				raw = crc_inv[31:24]; feed_en = 1'b0; pos_nxt = scft_pkg::P_CLOSE;
			end
			scft_pkg::P_CLOSE: begin
				raw = cfg.end_code; escapable = 1'b0; feed_en = 1'b0; finish = 1'b1;
				pos_nxt = scft_pkg::P_CLOSE;
			end
			default: begin
				escapable = 1'b0; feed_en = 1'b0; finish = 1'b1;
			end
		endcase
	end

	// SLIP escaping: an escaped byte is sent as the escape code, then its substitute; end code test first
	always_comb begin
		is_end     = raw == cfg.end_code;
		is_esc     = raw == cfg.esc_code;
		first_half = escapable && (is_end || is_esc) && !esc2_q;
		if (first_half) begin
			out_byte = cfg.esc_code;
		end else if (esc2_q) begin
			out_byte = is_end ? cfg.esc_end : cfg.esc_esc;
		end else begin
			out_byte = raw;
		end
	end

	assign advance    = step && !first_half;
	assign done       = advance && finish;
	assign desc_ready = !cur_v_q || done;

	// Position, escape phase and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= scft_pkg::P_OPEN;
			esc2_q  <= 1'b0;
			crc_q   <= scft_pkg::CRC_INIT;
		end else begin
			if (desc_valid && desc_ready) begin
				cur_v_q <= 1'b1;
				pos_q   <= desc.start ? scft_pkg::P_OPEN : scft_pkg::P_DATA;
				esc2_q  <= 1'b0;
			end else begin
				if (step) begin
					esc2_q <= first_half;
				end
				if (advance) begin
					pos_q <= pos_nxt;
				end
				if (done) begin
					cur_v_q <= 1'b0;
				end
			end
			if (advance) begin
				if (pos_q == scft_pkg::P_OPEN || pos_q == scft_pkg::P_CLOSE) begin
					crc_q <= scft_pkg::CRC_INIT;
				end else if (feed_en) begin
					crc_q <= scft_pkg::crc_feed(crc_q, raw);
				end
			end
		end
	end

	// Descriptor holding register
	always_ff @(posedge clk) begin
		if (desc_valid && desc_ready) begin
			desc_q <= desc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= out_byte;
			m_tlast_q <= done;
			m_tuser_q <= advance && (pos_q == scft_pkg::P_CLOSE);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule
